### design/ifs_pkg.sv
// ----------------------------------------------------------------------------
// Integer field scanner package
// Shared types, register indexes, codes and character constants.
// ----------------------------------------------------------------------------
package ifs_pkg;

  // Default parameter values
  localparam int unsigned INT_BITS_DEF    = 32;
  localparam int unsigned ACC_BITS_DEF    = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Field widths
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned WIDTH_W    = 15;
  localparam int unsigned VALUE_W    = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE  = 2'd2;

  // Base codes (unused code acts as decimal)
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  // Size codes (unused code acts as long)
  localparam logic [1:0] SIZE_SHORT   = 2'd0;
  localparam logic [1:0] SIZE_REGULAR = 2'd1;
  localparam logic [1:0] SIZE_LONG    = 2'd2;

  // Field width used when the register holds zero
  localparam logic [WIDTH_W-1:0] DEFAULT_WIDTH = 15'd30000;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] LOWER_OFS = 8'd87;  // 'a' - 10
  localparam logic [7:0] UPPER_OFS = 8'd55;  // 'A' - 10

  // Configuration registers
  typedef struct packed {
    logic [1:0]         base;
    logic [WIDTH_W-1:0] width;
    logic [1:0]         size;
  } cfg_t;

  // Classified character, front to back
  typedef struct packed {
    logic       eot;
    logic       blank;
    logic       sign;
    logic       minus;
    logic       dig_ok;
    logic [3:0] dig;
  } cls_t;

  // Result request
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               matched;
    logic               reached_end;
  } res_t;

endpackage

### design/integer_field_scanner_core.sv
// A field's result passes from the back end into the result queue before it reaches the result ports.
// Throughput: one character per cycle; the back end stalls only when the result queue is full.
// The front and result queues each hold QUEUE_DEPTH requests.
// Reset is asynchronous, active low: registers return to base decimal, width 0, size regular,
// and the scanner starts skipping blanks with both queues empty.
// ----------------------------------------------------------------------------
// Integer field scanner core
// Scans integer fields from a character stream, one character per request.
// ----------------------------------------------------------------------------
module integer_field_scanner_core #(
  parameter int unsigned INT_BITS    = ifs_pkg::INT_BITS_DEF,
  parameter int unsigned ACC_BITS    = ifs_pkg::ACC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = ifs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input side
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     ch_i,
  input  logic                           end_of_text_i,
  // result side
  output logic                           empty,
  input  logic                           pop,
  output logic signed [31:0]             value_o,
  output logic                           matched_o,
  output logic                           reached_end_o,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [ifs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ifs_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  ifs_pkg::cfg_t cfg_q;
  ifs_pkg::cls_t cmd;
  ifs_pkg::res_t res, res_out;
  logic          cmd_valid, cmd_pop;
  logic          res_push, res_full;
  logic [$bits(ifs_pkg::res_t)-1:0] res_raw;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base  <= ifs_pkg::BASE_DEC;
      cfg_q.width <= '0;
      cfg_q.size  <= ifs_pkg::SIZE_REGULAR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ifs_pkg::CFG_IDX_BASE:  cfg_q.base  <= cfg_wdata_i[1:0];
        ifs_pkg::CFG_IDX_WIDTH: cfg_q.width <= cfg_wdata_i[ifs_pkg::WIDTH_W-1:0];
        ifs_pkg::CFG_IDX_SIZE:  cfg_q.size  <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Front end: classify and queue
  ifs_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .ch_i          (ch_i),
    .end_of_text_i (end_of_text_i),
    .base_i        (cfg_q.base),
    .full_o        (full),
    .cmd_pop_i     (cmd_pop),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd)
  );

  // Back end: field scanning
  ifs_back #(
    .INT_BITS (INT_BITS),
    .ACC_BITS (ACC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (!res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Result queue
  ifs_fifo #(
    .WIDTH ($bits(ifs_pkg::res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .din_i   (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .dout_o  (res_raw),
    .empty_o (empty)
  );

  assign res_out       = ifs_pkg::res_t'(res_raw);
  assign value_o       = res_out.value;
  assign matched_o     = res_out.matched;
  assign reached_end_o = res_out.reached_end;

`ifndef SYNTHESIS
  // A result only comes from a character the back end consumed
  a_res_from_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> cmd_pop)
    else $error("result pushed without a consumed character");

  // End of text always finishes the field
  a_eot_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && cmd.eot) |-> res_push)
    else $error("end of text did not finish the field");

  // An unmatched field reports value zero
  a_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !res.matched) |-> (res.value == '0))
    else $error("unmatched field with non-zero value");
`endif

endmodule

### design/ifs_fifo.sv
// ----------------------------------------------------------------------------
// Integer field scanner queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ifs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

### design/ifs_front.sv
// ----------------------------------------------------------------------------
// Integer field scanner front end
// Accepts characters, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ifs_front #(
  parameter int unsigned QUEUE_DEPTH = ifs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    ch_i,
  input  logic          end_of_text_i,
  input  logic [1:0]    base_i,
  output logic          full_o,
  input  logic          cmd_pop_i,
  output logic          cmd_valid_o,
  output ifs_pkg::cls_t cmd_o
);

  ifs_pkg::cls_t      cls;
  logic               is_dec, is_lo, is_up;
  logic [7:0]         d8;
  logic               cmd_empty;
  logic [$bits(ifs_pkg::cls_t)-1:0] cmd_raw;

  // Character classification
  always_comb begin
    is_dec = (ch_i >= ifs_pkg::CH_0)  && (ch_i <= ifs_pkg::CH_9);
    is_lo  = (ch_i >= ifs_pkg::CH_LA) && (ch_i <= ifs_pkg::CH_LF);
    is_up  = (ch_i >= ifs_pkg::CH_UA) && (ch_i <= ifs_pkg::CH_UF);
    d8     = ch_i - ifs_pkg::CH_0;
    if (is_lo) begin
      d8 = ch_i - ifs_pkg::LOWER_OFS;
    end else if (is_up) begin
      d8 = ch_i - ifs_pkg::UPPER_OFS;
    end
    cls.eot    = end_of_text_i;
    cls.blank  = (ch_i == ifs_pkg::CH_SPACE) || (ch_i == ifs_pkg::CH_TAB) ||
                 (ch_i == ifs_pkg::CH_NL);
    cls.sign   = (ch_i == ifs_pkg::CH_MINUS) || (ch_i == ifs_pkg::CH_PLUS);
    cls.minus  = (ch_i == ifs_pkg::CH_MINUS);
    // letters count as digits in hex only
    cls.dig_ok = is_dec || ((base_i == ifs_pkg::BASE_HEX) && (is_lo || is_up));
    cls.dig    = d8[3:0];
  end

  // Queue towards the back end
  ifs_fifo #(
    .WIDTH ($bits(ifs_pkg::cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .din_i   (cls),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .dout_o  (cmd_raw),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;
  assign cmd_o       = ifs_pkg::cls_t'(cmd_raw);

endmodule

### design/ifs_back.sv
// ----------------------------------------------------------------------------
// Integer field scanner back end: runs the field state and digit accumulation,
// one character per cycle while the result queue is not full.
// ----------------------------------------------------------------------------
module ifs_back #(
  parameter int unsigned INT_BITS = ifs_pkg::INT_BITS_DEF,
  parameter int unsigned ACC_BITS = ifs_pkg::ACC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ifs_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  ifs_pkg::cls_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_ready_i,
  output logic          res_push_o,
  output ifs_pkg::res_t res_o
);

  localparam int unsigned SH = ifs_pkg::VALUE_W - INT_BITS;

  logic                        in_digits_q, in_digits_d;
  logic [ifs_pkg::WIDTH_W-1:0] width_left_q, width_left_d;
  logic [ACC_BITS-1:0]         acc_q, acc_d;
  logic                        neg_q, neg_d;
  logic                        seen_q, seen_d;

  logic [ifs_pkg::WIDTH_W-1:0] len;
  logic [ACC_BITS-1:0]         acc_sh, acc_add;
  logic                        finish, fin_end;
  logic [31:0]                 low, sval;
  logic signed [31:0]          shl, reg_val;

  assign cmd_pop_o = cmd_valid_i && res_ready_i;
  assign len = (cfg_i.width == '0) ? ifs_pkg::DEFAULT_WIDTH : cfg_i.width;

  // Accumulator shift-add for the selected base
  always_comb begin
    case (cfg_i.base)
      ifs_pkg::BASE_OCT: acc_sh = acc_q << 3;
      ifs_pkg::BASE_HEX: acc_sh = acc_q << 4;
      default:           acc_sh = (acc_q << 3) + (acc_q << 1);
    endcase
    acc_add = acc_sh + ACC_BITS'(cmd_i.dig);
  end

  // Field state update
  always_comb begin
    in_digits_d  = in_digits_q;
    width_left_d = width_left_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    seen_d       = seen_q;
    finish       = 1'b0;
    fin_end      = 1'b0;
    if (in_digits_q) begin
      if ((width_left_q == '0) || cmd_i.eot) begin
        finish  = 1'b1;
        fin_end = cmd_i.eot;
      end else if (!cmd_i.dig_ok) begin
        finish = 1'b1;
      end else begin
        acc_d        = acc_add;
        seen_d       = 1'b1;
        width_left_d = width_left_q - ifs_pkg::WIDTH_W'(1);
      end
    end else if (cmd_i.eot) begin
      finish  = 1'b1;
      fin_end = 1'b1;
    end else if (!cmd_i.blank) begin
      in_digits_d = 1'b1;
      if (cmd_i.sign) begin
        neg_d        = cmd_i.minus;
        width_left_d = len - ifs_pkg::WIDTH_W'(1);
      end else if (!cmd_i.dig_ok) begin
        finish = 1'b1;
      end else begin
        // first digit: accumulator is zero here
        acc_d        = ACC_BITS'(cmd_i.dig);
        seen_d       = 1'b1;
        width_left_d = len - ifs_pkg::WIDTH_W'(1);
      end
    end
    if (finish) begin
      in_digits_d  = 1'b0;
      width_left_d = '0;
      acc_d        = '0;
      neg_d        = 1'b0;
      seen_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_digits_q  <= 1'b0;
      width_left_q <= '0;
      acc_q        <= '0;
      neg_q        <= 1'b0;
      seen_q       <= 1'b0;
    end else if (cmd_pop_o) begin
      in_digits_q  <= in_digits_d;
      width_left_q <= width_left_d;
      acc_q        <= acc_d;
      neg_q        <= neg_d;
      seen_q       <= seen_d;
    end
  end

  // Result value: negate, truncate to size, sign-extend
  always_comb begin
    low     = neg_q ? (32'd0 - acc_q[31:0]) : acc_q[31:0];
    shl     = low << SH;
    reg_val = shl >>> SH;
    case (cfg_i.size)
      ifs_pkg::SIZE_SHORT:   sval = {{16{low[15]}}, low[15:0]};
      ifs_pkg::SIZE_REGULAR: sval = reg_val;
      default:               sval = low;
    endcase
  end

  assign res_push_o        = cmd_pop_o && finish;
  assign res_o.value       = sval;
  assign res_o.matched     = seen_q;
  assign res_o.reached_end = fin_end;

endmodule

### tb/integer_field_scanner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer field scanner core testbench
// Feeds character streams through the push/full side and predicts each
// scanned field in step with the accepted characters. Every result popped
// from the block is compared field by field with the oldest prediction.
// Directed streams come first, then random fields under shifting register
// settings and several patterns of idling on both sides.
// ----------------------------------------------------------------------------
module integer_field_scanner_core_tb;
  import ifs_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned PHASE_CHARS    = 200;
  // Spare codes: base acts as decimal, size acts as long
  localparam logic [1:0] BASE_SPARE = 2'd3;
  localparam logic [1:0] SIZE_SPARE = 2'd3;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 15'h7FFF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            ch_i = 8'h00;
  logic                  end_of_text_i = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic signed [31:0]    value_o;
  logic                  matched_o;
  logic                  reached_end_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  integer_field_scanner_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .ch_i          (ch_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .value_o       (value_o),
    .matched_o     (matched_o),
    .reached_end_o (reached_end_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Register copies, at their reset values
  logic [1:0]         base_code = BASE_DEC;
  logic [WIDTH_W-1:0] width_reg = '0;
  logic [1:0]         size_code = SIZE_REGULAR;

  // Scanner state
  logic               in_field = 1'b0;
  logic [WIDTH_W-1:0] width_left = '0;
  logic [31:0]        acc_value = '0;
  logic               minus_taken = 1'b0;
  logic               digit_seen = 1'b0;

  res_t expected_fields[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned chars_sent = 0;
  int unsigned tx_idle_pct = 25;
  int unsigned rx_idle_pct = 25;
  bit          hold_req = 1'b0;

  initial begin : clock_gen
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit char_weight(input logic [7:0] c, output logic [3:0] w);
    w = '0;
    if (c >= CH_0 && c <= CH_9) begin
      w = 4'(c - CH_0);
      return 1'b1;
    end
    if (base_code == BASE_HEX) begin
      if (c >= CH_LA && c <= CH_LF) begin
        w = 4'(c - LOWER_OFS);
        return 1'b1;
      end
      if (c >= CH_UA && c <= CH_UF) begin
        w = 4'(c - UPPER_OFS);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Emit the field and go back to skipping blanks
  function automatic void close_field(input logic eot);
    logic [31:0] v;
    res_t        r;
    v = minus_taken ? -acc_value : acc_value;
    // regular is 32 bits at the default parameters, as is long
    if (size_code == SIZE_SHORT) v = {{16{v[15]}}, v[15:0]};
    r.value       = v;
    r.matched     = digit_seen;
    r.reached_end = eot;
    expected_fields.push_back(r);
    in_field    = 1'b0;
    width_left  = '0;
    acc_value   = '0;
    minus_taken = 1'b0;
    digit_seen  = 1'b0;
  endfunction

  function automatic void take_digit(input logic eot, input logic [7:0] c);
    logic [3:0] w;
    if (width_left == 0 || eot) begin
      close_field(eot);
    end else if (!char_weight(c, w)) begin
      close_field(1'b0);
    end else begin
      case (base_code)
        BASE_OCT: acc_value = acc_value << 3;
        BASE_HEX: acc_value = acc_value << 4;
        default:  acc_value = (acc_value << 3) + (acc_value << 1);
      endcase
      acc_value  = acc_value + 32'(w);
      digit_seen = 1'b1;
      width_left = width_left - 1'b1;
    end
  endfunction

  function automatic void scan_char(input logic [7:0] c, input logic eot);
    logic [WIDTH_W-1:0] len;
    len = (width_reg == 0) ? DEFAULT_WIDTH : width_reg;
    if (in_field) begin
      take_digit(eot, c);
    end else if (eot) begin
      close_field(1'b1);
    end else if (c != CH_SPACE && c != CH_TAB && c != CH_NL) begin
      in_field = 1'b1;
      if (c == CH_MINUS || c == CH_PLUS) begin
        minus_taken = (c == CH_MINUS);
        width_left  = len - 1'b1;
      end else begin
        width_left = len;
        take_digit(1'b0, c);
      end
    end
  endfunction

  // ----------------------------------------------------------------- checking
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("ERROR at %0t: %s is %0h, expected %0h", $time, what, got, want);
  endtask

  // Accepted requests on both sides, register writes and the watchdog
  always @(posedge clk_i) begin : request_monitor
    res_t want;
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (push && !full) begin
      chars_sent++;
      scan_char(ch_i, end_of_text_i);
    end
    if (pop && !empty) begin
      if (expected_fields.size() == 0) begin
        note_mismatch("unexpected result value", value_o, '0);
      end else begin
        want = expected_fields.pop_front();
        if (value_o !== want.value) note_mismatch("value", value_o, want.value);
        if (matched_o !== want.matched)
          note_mismatch("matched", 32'(matched_o), 32'(want.matched));
        if (reached_end_o !== want.reached_end)
          note_mismatch("reached_end", 32'(reached_end_o), 32'(want.reached_end));
      end
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_BASE:  base_code = cfg_wdata_i[1:0];
        CFG_IDX_WIDTH: width_reg = cfg_wdata_i;
        CFG_IDX_SIZE:  size_code = cfg_wdata_i[1:0];
        default: ;
      endcase
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("integer_field_scanner_core: mismatch");
      $finish;
    end
  end

  // Result side: random idling, or a long hold when asked for
  initial begin : result_taker
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ------------------------------------------------------------------ driving
  task automatic send_char(input logic [7:0] c, input logic eot);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push          <= 1'b1;
    ch_i          <= c;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // Wait until every predicted field has come out and the pipeline is empty
  task automatic settle();
    stop_sending();
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ------------------------------------------------------------ random items
  function automatic logic [7:0] pick_digit();
    case (base_code)
      BASE_HEX: begin
        case ($urandom_range(2))
          0:       return CH_0 + 8'($urandom_range(9));
          1:       return CH_LA + 8'($urandom_range(5));
          default: return CH_UA + 8'($urandom_range(5));
        endcase
      end
      // 8 and 9 are taken in octal as well
      default: return CH_0 + 8'($urandom_range(9));
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  // Blanks, optional sign, digits, then a blank, a random byte, an end of text or nothing
  task automatic send_random_field();
    int unsigned n_dig;
    repeat ($urandom_range(2)) send_char(pick_blank(), 1'b0);
    if ($urandom_range(2) == 0) send_char($urandom_range(1) ? CH_MINUS : CH_PLUS, 1'b0);
    n_dig = ($urandom_range(6) == 0) ? $urandom_range(12, 8) : $urandom_range(4);
    repeat (n_dig) send_char(pick_digit(), 1'b0);
    case ($urandom_range(9))
      0, 1, 2, 3: send_char(pick_blank(), 1'b0);
      4, 5:       send_char(8'($urandom), 1'b1);
      6, 7:       send_char(8'($urandom), 1'b0);
      default: ;  // run straight into the next field
    endcase
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 1)) send_char(8'($urandom), ($urandom_range(3) == 0));
  endtask

  task automatic pick_settings();
    logic [WIDTH_W-1:0] w;
    case ($urandom_range(9))
      0, 1, 2: w = '0;
      3:       w = 15'd1;
      4:       w = 15'd2;
      5:       w = WIDTH_W'($urandom_range(8, 3));
      6:       w = DEFAULT_WIDTH;
      7:       w = WIDTH_MAX;
      default: w = WIDTH_W'($urandom_range(32767));
    endcase
    write_reg(CFG_IDX_BASE, {13'($urandom), 2'($urandom_range(3))});
    write_reg(CFG_IDX_WIDTH, w);
    write_reg(CFG_IDX_SIZE, {13'($urandom), 2'($urandom_range(3))});
  endtask

  // -------------------------------------------------------------------- tests
  // Blank skipping, signs, sign alone, end of text while skipping, odd bytes
  task automatic test_blank_and_sign();
    settle();
    write_reg(CFG_IDX_BASE, {13'd0, BASE_DEC});
    send_char(CH_SPACE, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_NL, 1'b0);
    send_text("-12x");
    send_char(CH_PLUS, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
  endtask

  // Octal taking 8 and 9, result cut to 16 bits
  task automatic test_octal_short();
    settle();
    write_reg(CFG_IDX_BASE, {13'd0, BASE_OCT});
    write_reg(CFG_IDX_SIZE, {13'd0, SIZE_SHORT});
    send_text("-899999");
    send_char(8'h00, 1'b1);
  endtask

  // Hex in both cases; the width runs out and the next byte closes the field
  task automatic test_hex_width_limit();
    settle();
    write_reg(CFG_IDX_BASE, {13'd0, BASE_HEX});
    write_reg(CFG_IDX_WIDTH, 15'd3);
    write_reg(CFG_IDX_SIZE, {13'd0, SIZE_LONG});
    send_text("aF7G");
  endtask

  // Spare base and size codes, the largest width the register holds
  task automatic test_spare_codes();
    settle();
    write_reg(CFG_IDX_BASE, {13'd0, BASE_SPARE});
    write_reg(CFG_IDX_WIDTH, WIDTH_MAX);
    write_reg(CFG_IDX_SIZE, {13'd0, SIZE_SPARE});
    send_text("9a");
  endtask

  // Width is latched when the field starts, not when it is rewritten
  task automatic test_width_taken_at_start();
    settle();
    write_reg(CFG_IDX_BASE, {13'd0, BASE_DEC});
    write_reg(CFG_IDX_WIDTH, 15'd2);
    send_char(CH_MINUS, 1'b0);
    settle();
    write_reg(CFG_IDX_WIDTH, DEFAULT_WIDTH);
    send_char(CH_0 + 8'd5, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  // Result side holds off while the input keeps coming, so full must rise
  task automatic test_result_backpressure();
    settle();
    write_reg(CFG_IDX_WIDTH, '0);
    write_reg(CFG_IDX_SIZE, {13'd0, SIZE_REGULAR});
    tx_idle_pct = 0;
    hold_req    = 1'b1;
    repeat (20) send_text("5;");
    settle();
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct);
    int unsigned start_count;
    int unsigned block_end;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start_count = chars_sent;
    while (chars_sent - start_count < PHASE_CHARS) begin
      settle();
      pick_settings();
      block_end = chars_sent + $urandom_range(60, 20);
      while (chars_sent < block_end) begin
        if ($urandom_range(7) == 0) send_noise();
        else send_random_field();
      end
    end
  endtask

  initial begin : test_sequence
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_blank_and_sign();
    test_octal_short();
    test_hex_width_limit();
    test_spare_codes();
    test_width_taken_at_start();
    test_result_backpressure();
    test_random_traffic(35, 85);
    test_random_traffic(85, 35);
    test_random_traffic(0, 0);
    settle();
    if (mismatch_count == 0) begin
      $display("integer_field_scanner_core: match");
    end else begin
      $display("integer_field_scanner_core: mismatch");
    end
    $finish;
  end

endmodule
